// ===== hw/rtl/app_pkg.sv =====
// Advert payload parser package: transaction types, register indexes and constants.
// Used by app_parser, app_out_queue and advert_payload_parser; depends on nothing.

package app_pkg;

  // Configuration register indexes
  localparam logic [7:0] RegLocMask     = 8'd0;
  localparam logic [7:0] RegFeatOneMask = 8'd1;
  localparam logic [7:0] RegFeatTwoMask = 8'd2;
  localparam logic [7:0] RegNameMask    = 8'd3;

  // Mask reset values
  localparam logic [7:0] LocMaskRst     = 8'h10;
  localparam logic [7:0] FeatOneMaskRst = 8'h20;
  localparam logic [7:0] FeatTwoMaskRst = 8'h40;
  localparam logic [7:0] NameMaskRst    = 8'h80;

  // Advert type sits in the low nibble of the flag byte
  localparam logic [7:0] TypeBits = 8'h0F;

  // Result kinds
  localparam logic KindName    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         name_char;
    logic [4:0]         name_index;
    logic               valid_res;
    logic [3:0]         pkt_type;
    logic               has_loc;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [15:0]        feat_one;
    logic [15:0]        feat_two;
    logic [4:0]         name_length;
    logic               has_name;
  } out_item_t;

  typedef struct packed {
    logic [7:0] loc;
    logic [7:0] feat_one;
    logic [7:0] feat_two;
    logic [7:0] name;
  } cfg_masks_t;

  // Everything one input byte produces: an optional name echo and an optional summary
  typedef struct packed {
    logic       has_echo;
    logic [7:0] echo_char;
    logic [4:0] echo_index;
    logic       has_sum;
    out_item_t  sum;
  } q_entry_t;

endpackage

// ===== hw/rtl/advert_payload_parser.sv =====
// Advert payload parser top level: mask registers, byte parser, result queue.
// Depends on app_pkg, app_parser and app_out_queue.
//
//  channel  direction  handshake                payload
//  -------  ---------  -----------------------  -------------------------------
//  in       input      in_valid_i / in_stall_o  in_item_i  (data byte, end mark)
//  out      output     out_valid_o/out_stall_i  out_item_o (echo or summary)
//  cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte per cycle unless the queue is full; its results are queued from the next cycle.
// A byte that both echoes a name byte and ends the packet gives two output
// transactions and holds its queue entry until both are taken; the two-entry
// queue sets the sustained rate: one byte per cycle while each byte gives at most one result.
// Input stall is high only while the queue is full; it does not look at out_stall_i.
// Reset clears the packet state and queue and loads the default masks; no clearing pass.

module advert_payload_parser #(
  parameter int unsigned NAME_CAP = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  app_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output app_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import app_pkg::*;

  cfg_masks_t masks_q;
  q_entry_t   entry;
  logic       accept, push, full;

  // configuration: always ready, writes beyond the register list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q.loc      <= LocMaskRst;
      masks_q.feat_one <= FeatOneMaskRst;
      masks_q.feat_two <= FeatTwoMaskRst;
      masks_q.name     <= NameMaskRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegLocMask:     masks_q.loc      <= cfg_data_i;
        RegFeatOneMask: masks_q.feat_one <= cfg_data_i;
        RegFeatTwoMask: masks_q.feat_two <= cfg_data_i;
        RegNameMask:    masks_q.name     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  // byte parser: field assembly and packet state
  app_parser #(
    .NAME_CAP(NAME_CAP)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .masks_i  (masks_q),
    .push_o   (push),
    .entry_o  (entry)
  );

  // result queue decouples output stalls from byte intake
  app_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hw/rtl/app_parser.sv =====
// Packet state registers and per-byte field assembly of the advert parser.
// Depends on app_pkg.

module app_parser #(
  parameter int unsigned NAME_CAP = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  app_pkg::in_item_t item_i,
  input  app_pkg::cfg_masks_t masks_i,
  output logic              push_o,
  output app_pkg::q_entry_t entry_o
);
  import app_pkg::*;

  localparam logic [8:0] NameCap   = 9'(NAME_CAP);
  localparam logic [8:0] NameCapM1 = 9'(NAME_CAP - 1);

  logic [7:0]  flag_q, flag_d, pos_q, pos_d, ncount_q, ncount_d;
  logic [31:0] lat_q, lat_d, lon_q, lon_d;
  logic [15:0] f1_q, f1_d, f2_q, f2_d;
  logic [2:0]  done_q, done_d;
  logic        first_nz_q, first_nz_d, ovf_q, ovf_d;

  logic        start;
  logic [7:0]  flag_cur, b, s1, s2, sn, pm1;
  logic        loc, f1, f2, nm;
  logic        loc_ok, f1_ok, f2_ok, groups, name_ok, valid, name_acc;
  logic [1:0]  lane4;
  logic        lane2;

  always_comb begin
    b        = item_i.data_byte;
    start    = !ovf_q && (pos_q == 8'd0);
    flag_cur = start ? b : flag_q;
    loc      = |(flag_cur & masks_i.loc);
    f1       = |(flag_cur & masks_i.feat_one);
    f2       = |(flag_cur & masks_i.feat_two);
    nm       = |(flag_cur & masks_i.name);

    s1    = 8'd1 + (loc ? 8'd8 : 8'd0);
    s2    = s1 + (f1 ? 8'd2 : 8'd0);
    sn    = s2 + (f2 ? 8'd2 : 8'd0);
    pm1   = pos_q - 8'd1;
    lane4 = pm1[1:0];
    lane2 = 1'b0;

    flag_d     = flag_q;
    pos_d      = pos_q;
    ncount_d   = ncount_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    f1_d       = f1_q;
    f2_d       = f2_q;
    done_d     = done_q;
    first_nz_d = first_nz_q;
    ovf_d      = ovf_q;
    entry_o    = '0;

    if (ovf_q || pos_q == 8'hFF) begin
      ovf_d = 1'b1;
    end else if (pos_q == 8'd0) begin
      flag_d     = b;
      pos_d      = 8'd1;
      ncount_d   = '0;
      lat_d      = '0;
      lon_d      = '0;
      f1_d       = '0;
      f2_d       = '0;
      done_d     = '0;
      first_nz_d = 1'b0;
    end else begin
      if (loc && pos_q <= 8'd4) begin
        lat_d[{lane4, 3'b000} +: 8] = lat_q[{lane4, 3'b000} +: 8] | b;
      end else if (loc && pos_q >= 8'd5 && pos_q <= 8'd8) begin
        lon_d[{lane4, 3'b000} +: 8] = lon_q[{lane4, 3'b000} +: 8] | b;
        if (pos_q == 8'd8) done_d[0] = 1'b1;
      end else if (f1 && pos_q >= s1 && pos_q < s1 + 8'd2) begin
        lane2 = pos_q[0] ^ s1[0];
        f1_d[{lane2, 3'b000} +: 8] = f1_q[{lane2, 3'b000} +: 8] | b;
        if (lane2) done_d[1] = 1'b1;
      end else if (f2 && pos_q >= s2 && pos_q < s2 + 8'd2) begin
        lane2 = pos_q[0] ^ s2[0];
        f2_d[{lane2, 3'b000} +: 8] = f2_q[{lane2, 3'b000} +: 8] | b;
        if (lane2) done_d[2] = 1'b1;
      end else if (nm && pos_q >= sn) begin
        if ({1'b0, ncount_q} < NameCapM1) begin
          entry_o.has_echo   = 1'b1;
          entry_o.echo_char  = b;
          entry_o.echo_index = ncount_q[4:0];
        end
        if (ncount_q == 8'd0) first_nz_d = (b != 8'd0);
        if (ncount_q != 8'hFF) ncount_d = ncount_q + 8'd1;
      end
      pos_d = pos_q + 8'd1;
    end

    // end-of-packet summary, built from the state this byte leaves
    loc_ok   = loc && done_d[0];
    f1_ok    = f1 && done_d[1];
    f2_ok    = f2 && done_d[2];
    groups   = (!loc || loc_ok) && (!f1 || f1_ok) && (!f2 || f2_ok);
    name_ok  = !nm || ({1'b0, ncount_d} < NameCap);
    valid    = !ovf_d && groups && name_ok;
    name_acc = valid && nm;

    if (item_i.end_mark) begin
      entry_o.has_sum         = 1'b1;
      entry_o.sum.kind        = KindSummary;
      entry_o.sum.valid_res   = valid;
      entry_o.sum.pkt_type    = 4'(flag_d & TypeBits);
      entry_o.sum.has_loc     = loc;
      entry_o.sum.latitude    = loc_ok ? lat_d : '0;
      entry_o.sum.longitude   = loc_ok ? lon_d : '0;
      entry_o.sum.feat_one    = f1_ok ? f1_d : '0;
      entry_o.sum.feat_two    = f2_ok ? f2_d : '0;
      entry_o.sum.name_length = name_acc ? ncount_d[4:0] : '0;
      entry_o.sum.has_name    = name_acc && (ncount_d != 8'd0) && first_nz_d;

      flag_d     = '0;
      pos_d      = '0;
      ncount_d   = '0;
      lat_d      = '0;
      lon_d      = '0;
      f1_d       = '0;
      f2_d       = '0;
      done_d     = '0;
      first_nz_d = 1'b0;
      ovf_d      = 1'b0;
    end

    push_o = accept_i && (entry_o.has_echo || entry_o.has_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= '0;
      pos_q      <= '0;
      ncount_q   <= '0;
      lat_q      <= '0;
      lon_q      <= '0;
      f1_q       <= '0;
      f2_q       <= '0;
      done_q     <= '0;
      first_nz_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (accept_i) begin
      flag_q     <= flag_d;
      pos_q      <= pos_d;
      ncount_q   <= ncount_d;
      lat_q      <= lat_d;
      lon_q      <= lon_d;
      f1_q       <= f1_d;
      f2_q       <= f2_d;
      done_q     <= done_d;
      first_nz_q <= first_nz_d;
      ovf_q      <= ovf_d;
    end
  end

  // overflow only ever starts from a saturated position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(pos_q) == 8'hFF)
    else $error("overflow set below saturated position");

  // overflow is only ever held while the position stays saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> pos_q == 8'hFF)
    else $error("overflow with unsaturated position");

  // summary always clears the packet state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.end_mark) |=> (pos_q == 8'd0 && !ovf_q && done_q == 3'd0))
    else $error("packet state not cleared after summary");

endmodule

// ===== hw/rtl/app_out_queue.sv =====
// Two-entry result queue; each entry yields a name echo and/or a summary transaction.
// Depends on app_pkg.

module app_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  app_pkg::q_entry_t  entry_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output app_pkg::out_item_t out_item_o
);
  import app_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              echo_done_q;

  q_entry_t head;
  logic     show_echo, take, last_sub, pop;

  always_comb begin
    head        = mem_q[rd_ptr_q];
    out_valid_o = (count_q != '0);
    full_o      = (count_q == CntW'(Depth));
    show_echo   = head.has_echo && !echo_done_q;
    take        = out_valid_o && !out_stall_i;
    last_sub    = !(show_echo && head.has_sum);
    pop         = take && last_sub;
    if (show_echo) begin
      out_item_o            = '0;
      out_item_o.kind       = KindName;
      out_item_o.name_char  = head.echo_char;
      out_item_o.name_index = head.echo_index;
    end else begin
      out_item_o = head.sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      echo_done_q <= 1'b0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop) begin
        count_q <= count_q - CntW'(1);
      end
      if (take) echo_done_q <= !last_sub;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (entry_i.has_echo || entry_i.has_sum))
    else $error("empty entry pushed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    echo_done_q |-> (out_valid_o && head.has_echo && head.has_sum))
    else $error("echo marked sent without a pending summary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count out of range");

endmodule

// ===== bench/advert_payload_parser_test.sv =====
// Self-checking bench for advert_payload_parser: packets of flag, location, feature and
// name bytes under several mask settings, scored by an in-bench parser model.
// Depends on app_pkg and the advert_payload_parser RTL.
`timescale 1ns / 100ps

module advert_payload_parser_test;
  import app_pkg::*;

  localparam int unsigned NameCap     = 32;
  localparam int          DrainCycles = 8;     // queue is two deep, allow a few more
  localparam int          PhaseBytes  = 240;   // per mask setting; ~2000 bytes in all
  localparam int          HoldCycles  = 200;   // long receiver hold-off

  typedef enum {PktGood, PktCut, PktLong} pkt_mode_e;

  // Parser model and store of expected output transactions
  class advert_tracker;
    out_item_t   pending_results[$];
    logic [7:0]  loc_mask, f1_mask, f2_mask, name_mask;
    logic [7:0]  flags, pos, name_cnt;
    logic [31:0] lat_acc, lon_acc;
    logic [15:0] f1_acc, f2_acc;
    logic [2:0]  done_bits;
    bit          first_nz, ovf;
    int          errors, summaries, valid_sums, echoes;

    function new();
      loc_mask  = LocMaskRst;
      f1_mask   = FeatOneMaskRst;
      f2_mask   = FeatTwoMaskRst;
      name_mask = NameMaskRst;
      clear_packet();
    endfunction

    function void clear_packet();
      flags     = '0;
      pos       = '0;
      name_cnt  = '0;
      lat_acc   = '0;
      lon_acc   = '0;
      f1_acc    = '0;
      f2_acc    = '0;
      done_bits = '0;
      first_nz  = 1'b0;
      ovf       = 1'b0;
    endfunction

    function void set_mask(logic [7:0] idx, logic [7:0] val);
      case (idx)
        RegLocMask:     loc_mask  = val;
        RegFeatOneMask: f1_mask   = val;
        RegFeatTwoMask: f2_mask   = val;
        RegNameMask:    name_mask = val;
        default: ;
      endcase
    endfunction

    // Work out what one accepted byte produces and queue it
    function void parse_byte(in_item_t it);
      logic [7:0]  b;
      logic [7:0]  type_byte;
      bit          loc, f1, f2, nm;
      bit          loc_ok, f1_ok, f2_ok, groups, name_ok, valid, name_acc;
      int unsigned p, s1, s2, sn;
      out_item_t   o;
      b   = it.data_byte;
      loc = (flags & loc_mask) != 0;
      f1  = (flags & f1_mask) != 0;
      f2  = (flags & f2_mask) != 0;
      nm  = (flags & name_mask) != 0;

      if (ovf || pos == 8'd255) begin
        ovf = 1'b1;                     // beyond 255 bytes nothing is parsed
      end else if (pos == 8'd0) begin
        clear_packet();
        flags = b;
        pos   = 8'd1;
        loc   = (flags & loc_mask) != 0;
        f1    = (flags & f1_mask) != 0;
        f2    = (flags & f2_mask) != 0;
        nm    = (flags & name_mask) != 0;
      end else begin
        p  = pos;
        s1 = 1 + (loc ? 8 : 0);
        s2 = s1 + (f1 ? 2 : 0);
        sn = s2 + (f2 ? 2 : 0);
        if (loc && p >= 1 && p <= 4) begin
          lat_acc |= 32'(b) << (8 * (p - 1));
        end else if (loc && p >= 5 && p <= 8) begin
          lon_acc |= 32'(b) << (8 * (p - 5));
          if (p == 8) done_bits[0] = 1'b1;
        end else if (f1 && p >= s1 && p < s1 + 2) begin
          f1_acc |= 16'(32'(b) << (8 * (p - s1)));
          if (p == s1 + 1) done_bits[1] = 1'b1;
        end else if (f2 && p >= s2 && p < s2 + 2) begin
          f2_acc |= 16'(32'(b) << (8 * (p - s2)));
          if (p == s2 + 1) done_bits[2] = 1'b1;
        end else if (nm && p >= sn) begin
          // echo stops one short of capacity
          if (32'(name_cnt) < NameCap - 1) begin
            o            = '0;
            o.kind       = KindName;
            o.name_char  = b;
            o.name_index = name_cnt[4:0];
            pending_results.push_back(o);
            echoes++;
          end
          if (name_cnt == 8'd0) first_nz = (b != 8'd0);
          if (name_cnt != 8'd255) name_cnt++;
        end
        pos++;
      end

      if (it.end_mark) begin
        loc_ok    = loc && done_bits[0];
        f1_ok     = f1 && done_bits[1];
        f2_ok     = f2 && done_bits[2];
        groups    = (!loc || loc_ok) && (!f1 || f1_ok) && (!f2 || f2_ok);
        name_ok   = !nm || (32'(name_cnt) < NameCap);
        valid     = !ovf && groups && name_ok;
        name_acc  = valid && nm;
        type_byte = flags & TypeBits;
        o             = '0;
        o.kind        = KindSummary;
        o.valid_res   = valid;
        o.pkt_type    = type_byte[3:0];
        o.has_loc     = loc;
        o.latitude    = loc_ok ? lat_acc : '0;
        o.longitude   = loc_ok ? lon_acc : '0;
        o.feat_one    = f1_ok ? f1_acc : '0;
        o.feat_two    = f2_ok ? f2_acc : '0;
        o.name_length = name_acc ? name_cnt[4:0] : '0;
        o.has_name    = name_acc && name_cnt != 8'd0 && first_nz;
        pending_results.push_back(o);
        summaries++;
        if (valid) valid_sums++;
        clear_packet();
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("output transaction with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind",        32'(want.kind),        32'(got.kind));
      compare_field("name_char",   32'(want.name_char),   32'(got.name_char));
      compare_field("name_index",  32'(want.name_index),  32'(got.name_index));
      compare_field("valid_res",   32'(want.valid_res),   32'(got.valid_res));
      compare_field("pkt_type",    32'(want.pkt_type),    32'(got.pkt_type));
      compare_field("has_loc",     32'(want.has_loc),     32'(got.has_loc));
      compare_field("latitude",    want.latitude,         got.latitude);
      compare_field("longitude",   want.longitude,        got.longitude);
      compare_field("feat_one",    32'(want.feat_one),    32'(got.feat_one));
      compare_field("feat_two",    32'(want.feat_two),    32'(got.feat_two));
      compare_field("name_length", 32'(want.name_length), 32'(got.name_length));
      compare_field("has_name",    32'(want.has_name),    32'(got.has_name));
    endfunction
  endclass

  // DUT connections, all inputs known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;

  advert_tracker tracker = new();
  logic [7:0]    pkt_bytes[$];
  int            bytes_sent = 0;
  int            settings   = 1;   // reset masks count as the first setting
  bit            quiet      = 1'b0; // no idling on either side
  bit            hold_req   = 1'b0; // ask the receiver for a long hold-off

  advert_payload_parser #(
    .NAME_CAP(NameCap)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: scores every output transaction, stalls in random bursts,
  // and on request holds off long enough to back the block up.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_item_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // One input transaction; valid stays up between back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    it.data_byte = b;
    it.end_mark  = last;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    tracker.parse_byte(it);
    bytes_sent++;
  endtask

  task automatic send_pkt();
    int k;
    for (k = 0; k < pkt_bytes.size(); k++) send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
  endtask

  // Random bytes with random end marks
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // Packet laid out for the masks in force; a cut one loses its tail,
  // a long one runs past 255 bytes.
  task automatic build_packet(input pkt_mode_e mode);
    logic [7:0] flags;
    int         len, r;
    pkt_bytes.delete();
    flags = 8'($urandom);
    if ($urandom_range(0, 1) == 1) flags |= tracker.name_mask;
    pkt_bytes.push_back(flags);
    if (mode == PktLong) begin
      len = $urandom_range(256, 262);
      while (pkt_bytes.size() < len) pkt_bytes.push_back(8'($urandom));
      return;
    end
    if ((flags & tracker.loc_mask) != 0) repeat (8) pkt_bytes.push_back(8'($urandom));
    if ((flags & tracker.f1_mask) != 0)  repeat (2) pkt_bytes.push_back(8'($urandom));
    if ((flags & tracker.f2_mask) != 0)  repeat (2) pkt_bytes.push_back(8'($urandom));
    if ((flags & tracker.name_mask) != 0) begin
      r = $urandom_range(0, 9);
      if (r < 7)      len = $urandom_range(0, 10);
      else if (r < 9) len = $urandom_range(NameCap - 3, NameCap + 1);   // around capacity
      else            len = $urandom_range(NameCap + 2, NameCap + 12);
      repeat (len) pkt_bytes.push_back(8'($urandom));
      if (len > 0 && $urandom_range(0, 3) == 0) pkt_bytes[pkt_bytes.size() - len] = 8'h00;
    end else begin
      repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
    end
    if (mode == PktCut && pkt_bytes.size() > 1) begin
      len = $urandom_range(1, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
    end
  endtask

  // Quiet the input and let every expected transaction come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_masks(input cfg_masks_t masks);
    logic [7:0] order[4] = '{RegLocMask, RegFeatOneMask, RegFeatTwoMask, RegNameMask};
    logic [7:0] val;
    int         k;
    for (k = 0; k < 4; k++) begin
      case (order[k])
        RegLocMask:     val = masks.loc;
        RegFeatOneMask: val = masks.feat_one;
        RegFeatTwoMask: val = masks.feat_two;
        default:        val = masks.name;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_mask(order[k], val);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Hand-picked packets under the reset masks
  task automatic run_directed();
    pkt_bytes = {8'h00};                       // flag byte alone, nothing flagged
    send_pkt();
    pkt_bytes = {8'hFF};                       // everything flagged, nothing arrives
    send_pkt();
    // all groups plus a name; latitude and longitude at the signed extremes
    pkt_bytes = {8'hF3, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h41, 8'h00};
    send_pkt();
    pkt_bytes = {8'h6A, 8'h11, 8'h22, 8'h33}; // second feature word cut short
    send_pkt();
    pkt_bytes = {8'h05, 8'hAB, 8'hCD};        // trailing bytes without a name flag
    send_pkt();
    pkt_bytes = {8'h80, 8'h00, 8'h7E};        // name whose first byte is zero
    send_pkt();
  endtask

  initial begin : stimulus
    cfg_masks_t masks;
    int         ph, target, r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();

    for (ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1:       masks = '{loc: 8'hFF, feat_one: 8'hFF, feat_two: 8'hFF, name: 8'hFF};
          2:       masks = '{loc: 8'h00, feat_one: 8'h00, feat_two: 8'h00, name: 8'h00};
          3:       masks = '{loc: 8'(1 << $urandom_range(0, 7)),
                             feat_one: 8'(1 << $urandom_range(0, 7)),
                             feat_two: 8'(1 << $urandom_range(0, 7)),
                             name: 8'(1 << $urandom_range(0, 7))};
          4:       masks = '{loc: 8'($urandom), feat_one: 8'($urandom),
                             feat_two: 8'($urandom), name: 8'($urandom)};
          default: masks = '{loc: LocMaskRst, feat_one: FeatOneMaskRst,
                             feat_two: FeatTwoMaskRst, name: NameMaskRst};
        endcase
        write_masks(masks);
      end
      if (ph == 5) quiet = 1'b1;               // closing stretch runs flat out
      if (ph == 3) hold_req = 1'b1;            // back the block up once
      if (ph == 1 || ph == 4) begin
        build_packet(PktLong);
        send_pkt();
      end
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          build_packet(PktGood);
          send_pkt();
        end else if (r < 17) begin
          build_packet(PktCut);
          send_pkt();
        end else begin
          send_noise();
        end
      end
    end

    drain();
    if (tracker.pending_results.size() != 0) begin
      $error("%0d expected transactions never arrived", tracker.pending_results.size());
      tracker.errors++;
    end
    $display("Sent %0d bytes over %0d mask settings.", bytes_sent, settings);
    $display("Scored %0d summaries (%0d valid) and %0d name echoes.",
             tracker.summaries, tracker.valid_sums, tracker.echoes);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/app_pkg.sv
hw/rtl/app_parser.sv
hw/rtl/app_out_queue.sv
hw/rtl/advert_payload_parser.sv
bench/advert_payload_parser_test.sv
